/* hw/rtl/bba_pkg.sv */
`default_nettype none

package bba_pkg;

  // Default geometry of the pool.
  localparam int unsigned MIN_ORDER_DEF = 5;
  localparam int unsigned LEVELS_DEF    = 10;

  // Field widths of the two channels and of the header register.
  localparam int unsigned REQ_W    = 32;
  localparam int unsigned OFF_W    = 15;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GORD_W   = 4;
  localparam int unsigned HDR_W    = 8;

  localparam logic [HDR_W-1:0] HDR_RESET = 8'd32;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOBLK   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  // Commands from the controller to the datapath.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_INIT_ROOT,
    CMD_LOAD,
    CMD_SIZE_STEP,
    CMD_RD_ROOT,
    CMD_PICK,
    CMD_DESC_RD,
    CMD_DESC_STEP,
    CMD_SPLIT,
    CMD_MARK_T,
    CMD_LEAF_RD,
    CMD_FREE_GO,
    CMD_MRG_RD,
    CMD_MRG_UP,
    CMD_SET_FREE,
    CMD_FIX_RD,
    CMD_FIX_WR,
    CMD_RES_NOBLK,
    CMD_RES_BAD,
    CMD_EMIT
  } bba_cmd_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic size_done;
    logic too_big;
    logic root_none;
    logic at_dsel;
    logic at_dreq;
    logic misaligned;
    logic leaf_bad;
    logic buddy_free;
    logic node_is_root;
  } bba_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/bba_if.sv */
`default_nettype none

// Request channel: one allocate or free per transfer.
interface bba_req_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [REQ_W-1:0]  request_bytes;
  logic [OFF_W-1:0]  release_offset;
  modport source (output valid, op, request_bytes, release_offset, input ready);
  modport sink (input valid, op, request_bytes, release_offset, output ready);
endinterface

// Response channel: one result per request.
interface bba_rsp_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    granted_offset;
  logic [GORD_W-1:0]   granted_order;
  modport source (output valid, status, granted_offset, granted_order, input ready);
  modport sink (input valid, status, granted_offset, granted_order, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bba_ram.sv */
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/bba_ctrl.sv */
`default_nettype none

module bba_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_op_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire bba_pkg::bba_stat_t stat_i,
  output bba_pkg::bba_cmd_e       cmd_o
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_INIT, S_IDLE, S_SIZE, S_PICK, S_DESC, S_DSTEP, S_SPLIT,
    S_LEAF, S_CHK, S_MERGE, S_MSTEP, S_FIX, S_FIXW, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and the command for the datapath in this cycle.
  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLR;
        if (stat_i.clr_done) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o   = CMD_INIT_ROOT;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = (in_op_i == OP_FREE) ? S_LEAF : S_SIZE;
        end
      end
      S_SIZE: begin
        if (!stat_i.size_done) begin
          cmd_o = CMD_SIZE_STEP;
        end else if (stat_i.too_big) begin
          cmd_o   = CMD_RES_NOBLK;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_RD_ROOT;
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        if (stat_i.root_none) begin
          cmd_o   = CMD_RES_NOBLK;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_PICK;
          state_d = S_DESC;
        end
      end
      S_DESC: begin
        if (stat_i.at_dsel) begin
          state_d = S_SPLIT;
        end else begin
          cmd_o   = CMD_DESC_RD;
          state_d = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd_o   = CMD_DESC_STEP;
        state_d = S_DESC;
      end
      S_SPLIT: begin
        if (stat_i.at_dreq) begin
          cmd_o   = CMD_MARK_T;
          state_d = S_FIX;
        end else begin
          cmd_o = CMD_SPLIT;
        end
      end
      S_LEAF: begin
        if (stat_i.misaligned) begin
          cmd_o   = CMD_RES_BAD;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_LEAF_RD;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.leaf_bad) begin
          cmd_o   = CMD_RES_BAD;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_FREE_GO;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (stat_i.node_is_root) begin
          cmd_o   = CMD_SET_FREE;
          state_d = S_FIX;
        end else begin
          cmd_o   = CMD_MRG_RD;
          state_d = S_MSTEP;
        end
      end
      S_MSTEP: begin
        if (stat_i.buddy_free) begin
          cmd_o   = CMD_MRG_UP;
          state_d = S_MERGE;
        end else begin
          cmd_o   = CMD_SET_FREE;
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (stat_i.node_is_root) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_FIX_RD;
          state_d = S_FIXW;
        end
      end
      S_FIXW: begin
        cmd_o   = CMD_FIX_WR;
        state_d = S_FIX;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bba_dp.sv */
`default_nettype none

module bba_dp #(
  parameter int unsigned MIN_ORDER = bba_pkg::MIN_ORDER_DEF,
  parameter int unsigned LEVELS    = bba_pkg::LEVELS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bba_pkg::bba_cmd_e              cmd_i,
  output bba_pkg::bba_stat_t                  stat_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bba_pkg::HDR_W-1:0]      cfg_wdata_i,
  input  wire logic [bba_pkg::REQ_W-1:0]      request_bytes_i,
  input  wire logic [bba_pkg::OFF_W-1:0]      release_offset_i,
  output logic      [bba_pkg::STATUS_W-1:0]   status_o,
  output logic      [bba_pkg::OFF_W-1:0]      granted_offset_o,
  output logic      [bba_pkg::GORD_W-1:0]     granted_order_o
);
  import bba_pkg::*;

  localparam int unsigned TOP = MIN_ORDER + LEVELS;
  localparam int unsigned NW  = LEVELS + 1;
  localparam int unsigned MW  = LEVELS + 1;
  localparam int unsigned DW  = $clog2(LEVELS + 1);
  localparam int unsigned OW  = $clog2(TOP + 2);
  localparam int unsigned EW  = (TOP > OFF_W) ? TOP : OFF_W;
  localparam int unsigned SW  = TOP + HDR_W + 1;
  localparam int unsigned NEED_W = REQ_W + 1;

  logic [HDR_W-1:0]  hdr_q;
  logic [NEED_W-1:0] need_q;
  logic [OW-1:0]     ord_q;
  logic [TOP-1:0]    start_q;
  logic [NW-1:0]     node_q;
  logic [DW-1:0]     depth_q, dsel_q, dreq_q;
  logic [LEVELS-1:0] clr_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [OFF_W-1:0]    res_off_q;
  logic [GORD_W-1:0]   res_ord_q;

  // Node summary memory, two copies for two read ports.
  logic          node_we;
  logic [NW-1:0] node_waddr, rd_addr_a, rd_addr_b;
  logic [MW-1:0] node_wdata, rdata_a, rdata_b;

  // Start mark and order memories, one entry per minimum block.
  logic              mark_we, mark_wdata, mark_rd;
  logic [LEVELS-1:0] mark_waddr, leaf_f, leaf_a;
  logic [OW-1:0]     ord_rd;

  // Alloc placement and free lookup values.
  logic [NW-1:0]  rel_node, free_node;
  logic [TOP-1:0] start_a;
  logic [SW-1:0]  off_sum;
  logic [31:0]    off32, ord32;
  logic [DW-1:0]  pick_d, dfree;
  logic           pick_found;
  logic [EW-1:0]  free_diff;

  assign leaf_f   = start_q[TOP-1:MIN_ORDER];
  assign rel_node = node_q ^ (NW'(1) << dreq_q);
  assign start_a  = TOP'(rel_node) << ord_q;
  assign leaf_a   = start_a[TOP-1:MIN_ORDER];
  assign off_sum  = SW'(start_a) + SW'(hdr_q);
  assign off32    = 32'(off_sum);
  assign ord32    = 32'(ord_q);
  assign dfree    = DW'(OW'(TOP) - ord_rd);
  assign free_node = (NW'(1) << dfree) | NW'(start_q >> ord_rd);
  assign free_diff = EW'(release_offset_i) - EW'(hdr_q);

  // Deepest free level at or above the wanted size, from the root summary.
  always_comb begin
    pick_d     = '0;
    pick_found = 1'b0;
    for (int d = 0; d < MW; d++) begin
      if (DW'(d) <= dreq_q && rdata_a[d]) begin
        pick_d     = DW'(d);
        pick_found = 1'b1;
      end
    end
  end

  // Status flags for the controller.
  always_comb begin
    stat_o.clr_done     = &clr_q;
    stat_o.too_big      = ord_q > OW'(TOP);
    stat_o.size_done    = stat_o.too_big || (need_q <= (NEED_W'(1) << ord_q));
    stat_o.root_none    = !pick_found;
    stat_o.at_dsel      = depth_q == dsel_q;
    stat_o.at_dreq      = depth_q == dreq_q;
    stat_o.misaligned   = |start_q[MIN_ORDER-1:0];
    stat_o.leaf_bad     = !mark_rd || ord_rd < OW'(MIN_ORDER) || ord_rd > OW'(TOP);
    stat_o.buddy_free   = rdata_a[depth_q];
    stat_o.node_is_root = node_q == NW'(1);
  end

  // Memory addresses and write data per command.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = node_q;
    node_wdata = '0;
    rd_addr_a  = {node_q[NW-2:0], 1'b0};
    rd_addr_b  = {node_q[NW-2:0], 1'b1};
    mark_we    = 1'b0;
    mark_waddr = leaf_f;
    mark_wdata = 1'b0;
    case (cmd_i)
      CMD_CLR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_q;
      end
      CMD_INIT_ROOT: begin
        node_we    = 1'b1;
        node_waddr = NW'(1);
        node_wdata = MW'(1);
      end
      CMD_RD_ROOT: begin
        rd_addr_a = NW'(1);
      end
      CMD_SPLIT: begin
        node_we    = 1'b1;
        node_waddr = {node_q[NW-2:0], 1'b1};
        node_wdata = (MW'(1) << depth_q) << 1;
      end
      CMD_MARK_T: begin
        node_we    = 1'b1;
        mark_we    = 1'b1;
        mark_waddr = leaf_a;
        mark_wdata = 1'b1;
      end
      CMD_FREE_GO: begin
        mark_we = 1'b1;
      end
      CMD_MRG_RD: begin
        rd_addr_a = node_q ^ NW'(1);
      end
      CMD_SET_FREE: begin
        node_we    = 1'b1;
        node_wdata = MW'(1) << depth_q;
      end
      CMD_FIX_RD: begin
        rd_addr_a = {node_q[NW-1:1], 1'b0};
        rd_addr_b = {node_q[NW-1:1], 1'b1};
      end
      CMD_FIX_WR: begin
        node_we    = 1'b1;
        node_wdata = rdata_a | rdata_b;
      end
      default: begin
      end
    endcase
  end

  // Control registers: header size and the clear sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= HDR_RESET;
      clr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        hdr_q <= cfg_wdata_i;
      end
      if (cmd_i == CMD_CLR) begin
        clr_q <= clr_q + LEVELS'(1);
      end
    end
  end

  // Working registers and results.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        need_q  <= NEED_W'(request_bytes_i) + NEED_W'(hdr_q);
        ord_q   <= OW'(MIN_ORDER);
        start_q <= free_diff[TOP-1:0];
      end
      CMD_SIZE_STEP: ord_q <= ord_q + OW'(1);
      CMD_RD_ROOT:   dreq_q <= DW'(OW'(TOP) - ord_q);
      CMD_PICK: begin
        dsel_q  <= pick_d;
        node_q  <= NW'(1);
        depth_q <= '0;
      end
      CMD_DESC_STEP: begin
        node_q  <= {node_q[NW-2:0], !rdata_a[dsel_q]};
        depth_q <= depth_q + DW'(1);
      end
      CMD_SPLIT: begin
        node_q  <= {node_q[NW-2:0], 1'b0};
        depth_q <= depth_q + DW'(1);
      end
      CMD_MARK_T: begin
        res_status_q <= ST_OK;
        res_off_q    <= off32[OFF_W-1:0];
        res_ord_q    <= ord32[GORD_W-1:0];
      end
      CMD_FREE_GO: begin
        node_q  <= free_node;
        depth_q <= dfree;
      end
      CMD_MRG_UP: begin
        node_q  <= node_q >> 1;
        depth_q <= depth_q - DW'(1);
      end
      CMD_SET_FREE: begin
        res_status_q <= ST_OK;
        res_off_q    <= '0;
        res_ord_q    <= '0;
      end
      CMD_FIX_RD: node_q <= node_q >> 1;
      CMD_RES_NOBLK: begin
        res_status_q <= ST_NOBLK;
        res_off_q    <= '0;
        res_ord_q    <= '0;
      end
      CMD_RES_BAD: begin
        res_status_q <= ST_BADFREE;
        res_off_q    <= '0;
        res_ord_q    <= '0;
      end
      CMD_EMIT: begin
        status_o         <= res_status_q;
        granted_offset_o <= res_off_q;
        granted_order_o  <= res_ord_q;
      end
      default: begin
      end
    endcase
  end

  bba_ram #(.WIDTH(MW), .DEPTH(2 ** NW)) u_node_a (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(rd_addr_a), .rdata_o(rdata_a)
  );

  bba_ram #(.WIDTH(MW), .DEPTH(2 ** NW)) u_node_b (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(rd_addr_b), .rdata_o(rdata_b)
  );

  bba_ram #(.WIDTH(1), .DEPTH(2 ** LEVELS)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .raddr_i(leaf_f), .rdata_o(mark_rd)
  );

  bba_ram #(.WIDTH(OW), .DEPTH(2 ** LEVELS)) u_order (
    .clk_i, .we_i(cmd_i == CMD_MARK_T), .waddr_i(leaf_a), .wdata_i(ord_q),
    .raddr_i(leaf_f), .rdata_o(ord_rd)
  );

endmodule

`default_nettype wire

/* hw/rtl/buddy_block_allocator_top.sv */
`default_nettype none

// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    op, request_bytes, release_offset
// rsp_o     out  valid/ready    status, granted_offset, granted_order
// cfg       in   cfg_we_i       cfg_wdata_i (header bytes)
//
// One request at a time. An allocate takes its size steps, a read and a step per
// level down to the free block at depth p, one split per level down to the granted
// depth d, and a read and write per level to refresh the summaries up to the root.
// A free checks the block, merges it with free buddies and refreshes the summaries.
// After reset the start marks are cleared before any request is taken.
// A finished result waits in the output register while the next request is taken.

module buddy_block_allocator_top #(
  parameter int unsigned MIN_ORDER = bba_pkg::MIN_ORDER_DEF,
  parameter int unsigned LEVELS    = bba_pkg::LEVELS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  bba_req_if.sink                        req_i,
  bba_rsp_if.source                      rsp_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bba_pkg::HDR_W-1:0] cfg_wdata_i
);
  import bba_pkg::*;

  bba_cmd_e  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_i.valid), .in_op_i(req_i.op), .in_ready_o(req_i.ready),
    .out_valid_o(rsp_o.valid), .out_ready_i(rsp_o.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  bba_dp #(.MIN_ORDER(MIN_ORDER), .LEVELS(LEVELS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i, .cfg_wdata_i,
    .request_bytes_i(req_i.request_bytes), .release_offset_i(req_i.release_offset),
    .status_o(rsp_o.status), .granted_offset_o(rsp_o.granted_offset),
    .granted_order_o(rsp_o.granted_order)
  );

  // A transfer in starts work, so the next cycle takes no other request.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while busy");

  // A failed request carries no offset and no order.
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_OK |->
      rsp_o.granted_offset == '0 && rsp_o.granted_order == '0)
    else $error("failed result with payload");

endmodule

`default_nettype wire
